### rtl/core/tpl_pkg.sv
// ============================================================================
// tpl_pkg: shared types and constants for the tunnel polar lookup
// Widths of the datapath stages, the arctangent table and register indexes.
// ============================================================================
package tpl_pkg;

    localparam int COORD_W      = 14;  // 2*sub_step*index + 1
    localparam int SQ_W         = 28;  // coordinate squared
    localparam int SUM_W        = 29;  // X*X + Y*Y
    localparam int NSQ_W        = 32;  // distance_period squared
    localparam int DVD_W        = 50;  // (period*512)^2
    localparam int DIV_STEPS    = DVD_W;
    localparam int ROOT_W       = DVD_W / 2;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int SREM_W       = ROOT_W + 2;
    localparam int CORDIC_STEPS = 28;
    localparam int CX_W         = 34;
    localparam int Z_W          = 33;
    localparam int TURN_W       = 30;
    localparam int ANG_W        = 24;  // angle_period * 32 bits >> 24

    // Register stage numbers, counted from the input register as stage 1
    localparam int ANG_STAGE    = 3 + CORDIC_STEPS;                 // product register
    localparam int LAT          = 3 + DIV_STEPS + SQRT_STEPS;       // output register
    localparam int ANG_DLY      = LAT - ANG_STAGE;

    // atan(2^-i)/pi in units of 2^-31
    localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5
    };

    typedef enum logic [1:0] {
        REG_DIST_PERIOD  = 2'd0,
        REG_ANGLE_PERIOD = 2'd1,
        REG_SUB_STEP     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SUM_W-1:0] den;
        logic [SUM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;   // dividend bits shift out, quotient bits shift in
    } t_div_st;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [DVD_W-1:0]  rad;
    } t_sqrt_st;

    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
    } t_cordic_st;

endpackage

### rtl/core/tpl_div_stage.sv
// ============================================================================
// tpl_div_stage: one quotient bit of restoring division
// Shifts in the next dividend bit and subtracts the divisor when it fits.
// ============================================================================
module tpl_div_stage (
    input  logic              i_clk,
    input  logic              i_en,
    input  tpl_pkg::t_div_st  i_st,
    output tpl_pkg::t_div_st  o_st
);
    logic [tpl_pkg::SUM_W:0] t;
    logic                    q;
    tpl_pkg::t_div_st        n_st;
    tpl_pkg::t_div_st        r_st;

    assign t = {i_st.rem, i_st.dvd[tpl_pkg::DVD_W-1]};

    always_comb begin
        n_st.den = i_st.den;
        if (t >= {1'b0, i_st.den}) begin
            n_st.rem = tpl_pkg::SUM_W'(t - {1'b0, i_st.den});
            q        = 1'b1;
        end else begin
            n_st.rem = t[tpl_pkg::SUM_W-1:0];
            q        = 1'b0;
        end
        n_st.dvd = {i_st.dvd[tpl_pkg::DVD_W-2:0], q};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

### rtl/core/tpl_sqrt_stage.sv
// ============================================================================
// tpl_sqrt_stage: one root bit of digit-by-digit integer square root
// Brings down two radicand bits and tests 4*root+1 against the remainder.
// ============================================================================
module tpl_sqrt_stage (
    input  logic               i_clk,
    input  logic               i_en,
    input  tpl_pkg::t_sqrt_st  i_st,
    output tpl_pkg::t_sqrt_st  o_st
);
    logic [tpl_pkg::SREM_W+1:0] t;
    logic [tpl_pkg::SREM_W+1:0] trial;
    tpl_pkg::t_sqrt_st          n_st;
    tpl_pkg::t_sqrt_st          r_st;

    assign t     = {i_st.rem, i_st.rad[tpl_pkg::DVD_W-1 -: 2]};
    assign trial = {2'b00, i_st.root, 2'b01};

    always_comb begin
        n_st.rad = {i_st.rad[tpl_pkg::DVD_W-3:0], 2'b00};
        if (t >= trial) begin
            n_st.rem  = tpl_pkg::SREM_W'(t - trial);
            n_st.root = {i_st.root[tpl_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_st.rem  = t[tpl_pkg::SREM_W-1:0];
            n_st.root = {i_st.root[tpl_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

### rtl/core/tpl_cordic_stage.sv
// ============================================================================
// tpl_cordic_stage: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-STEP) and accumulates the angle.
// ============================================================================
module tpl_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tpl_pkg::t_cordic_st  i_st,
    output tpl_pkg::t_cordic_st  o_st
);
    logic signed [tpl_pkg::CX_W-1:0] dx;
    logic signed [tpl_pkg::CX_W-1:0] dy;
    logic signed [tpl_pkg::Z_W-1:0]  turn;
    tpl_pkg::t_cordic_st             n_st;
    tpl_pkg::t_cordic_st             r_st;

    // arithmetic shift is the floor shift
    assign dx   = i_st.cy >>> STEP;
    assign dy   = i_st.cx >>> STEP;
    assign turn = signed'({{(tpl_pkg::Z_W-tpl_pkg::TURN_W){1'b0}},
                           tpl_pkg::ATAN_TURNS[STEP]});

    always_comb begin
        if (!i_st.cy[tpl_pkg::CX_W-1]) begin
            n_st.cx = i_st.cx + dx;
            n_st.cy = i_st.cy - dy;
            n_st.z  = i_st.z + turn;
        end else begin
            n_st.cx = i_st.cx - dx;
            n_st.cy = i_st.cy + dy;
            n_st.z  = i_st.z - turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

### rtl/core/tunnel_polar_lookup_entry.sv
// ============================================================================
// tunnel_polar_lookup_entry: macroblock coordinate to polar texture lookup
// Gives period/radius as unsigned Q17.8 and scaled angle as unsigned Q16.8, per coordinate.
// ============================================================================
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata[15:0]  = {y_index, x_index}
// m_axis    out  tvalid/tready          tdata[63:0]  = {angle_value, distance_value}
// apb       in   psel/penable/pwrite    0x0 distance_period, 0x4 angle_period,
//                                       0x8 sub_step
//
// One transaction per clock sustained unless stalled; pipeline of 78 register stages.
// The depth is set by the distance path: 3 front stages, 50 restoring-division
// stages, then 25 square-root stages.
// The angle path (28 CORDIC stages plus scaling) finishes early and is held
// in a delay line to meet the distance result.
// A stall freezes the whole pipeline, bubbles included, while the output
// register is full and not taken.
// Synchronous reset clears the valid bits and sets the configuration registers to their defaults.
// ============================================================================
module tunnel_polar_lookup_entry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input coordinates
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] x_index, [15:8] y_index
    // lookup results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] distance_value, [63:32] angle_value
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LAT = tpl_pkg::LAT;

    // ---------------------------------------------------------------- config
    logic [15:0] r_dist_period;
    logic [15:0] r_angle_period;
    logic [4:0]  r_sub_step;
    logic        cfg_wr;
    tpl_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tpl_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_period  <= 16'd256;
            r_angle_period <= 16'd256;
            r_sub_step     <= 5'd1;
        end else if (cfg_wr) begin
            // addresses past the register list drop the write
            case (cfg_idx)
                tpl_pkg::REG_DIST_PERIOD:  r_dist_period  <= pwdata[15:0];
                tpl_pkg::REG_ANGLE_PERIOD: r_angle_period <= pwdata[15:0];
                tpl_pkg::REG_SUB_STEP:     r_sub_step     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tpl_pkg::REG_DIST_PERIOD:  prdata = {16'd0, r_dist_period};
            tpl_pkg::REG_ANGLE_PERIOD: prdata = {16'd0, r_angle_period};
            tpl_pkg::REG_SUB_STEP:     prdata = {27'd0, r_sub_step};
            default:                   prdata = 32'd0;
        endcase
    end

    // -------------------------------------------------------------- control
    // Advance every stage when the output slot is empty or being drained.
    logic           en;
    logic [LAT-1:0] r_vld;   // bit k is the valid of stage k+1

    assign en              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // ------------------------------------------------------- stages 1 to 3
    // Coordinates doubled to odd integers: X = 2*sub_step*x + 1.
    logic [tpl_pkg::COORD_W-1:0] r_x, r_y;
    logic [tpl_pkg::NSQ_W-1:0]   r_nsq, r_nsq2;
    logic [tpl_pkg::SQ_W-1:0]    r_xsq, r_ysq;
    logic [tpl_pkg::SUM_W-1:0]   r_sum;
    logic [tpl_pkg::DVD_W-1:0]   r_dvd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x    <= {13'(r_sub_step) * 13'(i_s_axis_tdata[7:0]), 1'b1};
            r_y    <= {13'(r_sub_step) * 13'(i_s_axis_tdata[15:8]), 1'b1};
            r_nsq  <= r_dist_period * r_dist_period;
            r_xsq  <= r_x * r_x;
            r_ysq  <= r_y * r_y;
            r_nsq2 <= r_nsq;
            r_sum  <= tpl_pkg::SUM_W'(r_xsq) + tpl_pkg::SUM_W'(r_ysq);
            // (period * 512)^2 = period^2 * 2^18
            r_dvd  <= {r_nsq2, 18'd0};
        end
    end

    // ------------------------------------------------ distance: N^2 / S
    tpl_pkg::t_div_st div_st [tpl_pkg::DIV_STEPS+1];

    assign div_st[0] = '{den: r_sum, rem: '0, dvd: r_dvd};

    for (genvar k = 0; k < tpl_pkg::DIV_STEPS; k++) begin : g_div
        tpl_div_stage u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (div_st[k]),
            .o_st  (div_st[k+1])
        );
    end

    // ------------------------------------------- distance: floor sqrt
    tpl_pkg::t_sqrt_st sqrt_st [tpl_pkg::SQRT_STEPS+1];

    assign sqrt_st[0] = '{rem: '0, root: '0, rad: div_st[tpl_pkg::DIV_STEPS].dvd};

    for (genvar j = 0; j < tpl_pkg::SQRT_STEPS; j++) begin : g_sqrt
        tpl_sqrt_stage u_sqrt (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (sqrt_st[j]),
            .o_st  (sqrt_st[j+1])
        );
    end

    // ---------------------------------------------------- angle: CORDIC
    // Start from (X, Y) << 16; the result never needs saturation here.
    tpl_pkg::t_cordic_st cor_st [tpl_pkg::CORDIC_STEPS+1];

    assign cor_st[0] = '{
        cx: signed'({4'd0, r_x, 16'd0}),
        cy: signed'({4'd0, r_y, 16'd0}),
        z:  '0
    };

    for (genvar i = 0; i < tpl_pkg::CORDIC_STEPS; i++) begin : g_cordic
        tpl_cordic_stage #(.STEP(i)) u_cordic (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (cor_st[i]),
            .o_st  (cor_st[i+1])
        );
    end

    // Clamp z to [0, 2^30], add the half turn, then scale by angle_period.
    localparam logic signed [tpl_pkg::Z_W-1:0] ZMAX = tpl_pkg::Z_W'(1) <<< 30;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    logic signed [tpl_pkg::Z_W-1:0] z_fin;
    logic [31:0]                    n_zsum;
    logic [31:0]                    r_zsum;
    logic [47:0]                    prod;
    logic [tpl_pkg::ANG_W-1:0]      r_ang;
    logic [tpl_pkg::ANG_W-1:0]      r_ang_dly [tpl_pkg::ANG_DLY];

    assign z_fin = cor_st[tpl_pkg::CORDIC_STEPS].z;

    always_comb begin
        priority if (z_fin < 0) begin
            n_zsum = HALF_TURN;
        end else if (z_fin > ZMAX) begin
            n_zsum = HALF_TURN + 32'(ZMAX[30:0]);
        end else begin
            n_zsum = HALF_TURN + 32'(z_fin[30:0]);
        end
    end

    assign prod = r_angle_period * r_zsum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zsum <= n_zsum;
            r_ang  <= prod[47:24];
            // hold the angle until the distance catches up
            r_ang_dly[0] <= r_ang;
            for (int d = 1; d < tpl_pkg::ANG_DLY; d++) begin
                r_ang_dly[d] <= r_ang_dly[d-1];
            end
        end
    end

    // ---------------------------------------------------------------- output
    assign o_m_axis_tdata = {
        {(32 - tpl_pkg::ANG_W){1'b0}}, r_ang_dly[tpl_pkg::ANG_DLY-1],
        {(32 - tpl_pkg::ROOT_W){1'b0}}, sqrt_st[tpl_pkg::SQRT_STEPS].root
    };
endmodule

### rtl/core/tpl_checker.sv
// ============================================================================
// tpl_checker: port-level checks for the tunnel polar lookup
// Watches the result handshake and the stall behavior of the pipeline.
// ============================================================================
module tpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);
    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // the input side stalls only behind a full, untaken output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not track output slot");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

bind tunnel_polar_lookup_entry tpl_checker u_tpl_checker (.*);
